[rtl/hash_chain_random_source_defines.svh]
// assertion macros used by hash_chain_random_source
`ifndef HASH_CHAIN_RANDOM_SOURCE_DEFINES_SVH
`define HASH_CHAIN_RANDOM_SOURCE_DEFINES_SVH

// same-cycle implication
`define HCRS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hcrs assertion failed");

// next-cycle implication
`define HCRS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hcrs assertion failed");

`endif

[rtl/hcrs_pkg.sv]
`timescale 1ns / 1ps
package hcrs_pkg;

	localparam int SeedBytes = 32;
	localparam int SeedBits  = 256;

	typedef enum logic [2:0] {
		FUNC_BYTE  = 3'd0,
		FUNC_BOOL  = 3'd1,
		FUNC_U16   = 3'd2,
		FUNC_U32   = 3'd3,
		FUNC_U64   = 3'd4,
		FUNC_BELOW = 3'd5,
		FUNC_ROLL  = 3'd6,
		FUNC_NONE  = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		ERR_OK         = 2'd0,
		ERR_NOT_SEEDED = 2'd1,
		ERR_ZERO_BOUND = 2'd2,
		ERR_RSVD       = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		REG_SEED0 = 2'd0,
		REG_SEED1 = 2'd1,
		REG_SEED2 = 2'd2,
		REG_SEED3 = 2'd3
	} reg_idx_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] sha_h0(input logic [2:0] i);
		logic [31:0] r;
		case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] sha_k(input logic [5:0] i);
		logic [31:0] r;
		case (i)
			6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491; 6'd2: r = 32'hb5c0fbcf;
			6'd3: r = 32'he9b5dba5; 6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
			6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5; 6'd8: r = 32'hd807aa98;
			6'd9: r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
			6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
			6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
			6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
			6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
			6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
			6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
			6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
			6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
			default: r = 32'hc67178f2;
		endcase
		return r;
	endfunction

endpackage

[rtl/hcrs_if.sv]
`timescale 1ns / 1ps
interface hcrs_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [31:0] bound;
	logic [31:0] numer;

	modport source (output valid, func, bound, numer, input ready);
	modport sink (input valid, func, bound, numer, output ready);
endinterface

interface hcrs_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;
	logic [1:0]  error;

	modport source (output valid, value, error, input ready);
	modport sink (input valid, value, error, output ready);
endinterface

[rtl/hcrs_sha_core.sv]
`timescale 1ns / 1ps
module hcrs_sha_core
	import hcrs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [255:0] block,
	output logic         done,
	output logic [255:0] digest
);

	logic [31:0] st_q [8];
	logic [31:0] w_q [16];
	logic [5:0]  rnd_q;
	logic        busy_q;
	logic        fin_q;
	logic [31:0] t1, t2, w_new;

	assign t1 = st_q[7] + bsig1(st_q[4]) + ((st_q[4] & st_q[5]) ^ (~st_q[4] & st_q[6]))
		+ sha_k(rnd_q) + w_q[0];
	assign t2 = bsig0(st_q[0])
		+ ((st_q[0] & st_q[1]) ^ (st_q[0] & st_q[2]) ^ (st_q[1] & st_q[2]));
	assign w_new = w_q[0] + ssig0(w_q[1]) + w_q[9] + ssig1(w_q[14]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			rnd_q  <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < 8; i++) begin
				st_q[i] <= sha_h0(3'(i));
				w_q[i]  <= block[255 - 32 * i -: 32];
			end
			w_q[8] <= 32'h80000000;
			for (int i = 9; i < 15; i++) begin
				w_q[i] <= '0;
			end
			w_q[15] <= 32'd256;
		end else if (busy_q) begin
			for (int i = 1; i < 8; i++) begin
				st_q[i] <= st_q[i-1];
			end
			st_q[4] <= st_q[3] + t1;
			st_q[0] <= t1 + t2;
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			digest[255 - 32 * i -: 32] = st_q[i] + sha_h0(3'(i));
		end
	end

	assign done = fin_q;

endmodule

[rtl/hcrs_divider.sv]
`timescale 1ns / 1ps
module hcrs_divider
	import hcrs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] rem
);

	logic [63:0] num_q;
	logic [31:0] rem_q;
	logic [31:0] div_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic [32:0] diff;

	assign trial = {rem_q, num_q[63]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[62:0], 1'b0};
			rem_q <= (trial >= {1'b0, div_q}) ? diff[31:0] : trial[31:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

[rtl/hash_chain_random_source.sv]
`timescale 1ns / 1ps
// channel | role   | payload
// req     | sink   | func, bound, numer
// rsp     | source | value, error
// cfg     | write  | cfg_we, cfg_index, cfg_wdata
// one byte drawn per cycle from the seed register, except while the seed is rehashed
// the seed is rehashed on the round unit once every 32 bytes
// below-bound and roll requests add two passes of the bit-serial divider
// plus a fresh 8-byte draw per rejected draw
// reset clears the seed and index; req is not ready until the response beat is taken
`include "hash_chain_random_source_defines.svh"
module hash_chain_random_source
	import hcrs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	hcrs_req_if.sink    req,
	hcrs_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DRAW = 6'b000010,
		S_HASH = 6'b000100,
		S_DIVM = 6'b001000,
		S_DIVX = 6'b010000,
		S_RESP = 6'b100000
	} state_t;

	state_t       state_q;
	logic [63:0]  sw_q [4];
	logic [255:0] seed_q;
	logic [5:0]   idx_q;
	logic [3:0]   left_q;
	logic [63:0]  acc_q;
	logic [63:0]  m_q;
	func_t        func_q;
	logic [31:0]  bound_q;
	logic [31:0]  numer_q;
	logic [63:0]  value_q;
	logic [1:0]   error_q;
	logic [7:0]   seed_byte;
	logic [63:0]  acc_next;
	logic         sha_start, sha_done;
	logic [255:0] digest;
	logic         div_start, div_done;
	logic [63:0]  div_num;
	logic [31:0]  div_rem;
	logic         accept;
	func_t        req_func;

	assign req_func  = func_t'(req.func);
	assign accept    = req.valid && req.ready;
	assign seed_byte = seed_q[8'(8'd255 - {idx_q[4:0], 3'b000}) -: 8];
	assign acc_next  = {acc_q[55:0], seed_byte};

	assign sha_start = (state_q == S_DRAW) && (idx_q == 6'(SeedBytes));
	assign div_start = (accept && (req_func == FUNC_BELOW || req_func == FUNC_ROLL)
		&& req.bound != 32'd0 && seed_q != '0)
		|| (state_q == S_DRAW && idx_q != 6'(SeedBytes) && left_q == 4'd1
		&& (func_q == FUNC_BELOW || func_q == FUNC_ROLL) && acc_next < m_q);
	assign div_num = accept ? 64'hffff_ffff_ffff_ffff : acc_next;

	hcrs_sha_core u_sha (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sha_start),
		.block  (seed_q),
		.done   (sha_done),
		.digest (digest)
	);

	hcrs_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (accept ? req.bound : bound_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = (state_q == S_RESP);
	assign rsp.value = value_q;
	assign rsp.error = error_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < 4; i++) begin
				sw_q[i] <= '0;
			end
			seed_q <= '0;
			idx_q  <= '0;
			left_q <= '0;
		end else begin
			if (cfg_we) begin
				sw_q[cfg_index] <= cfg_wdata;
				for (int i = 0; i < 4; i++) begin
					seed_q[255 - 64 * i -: 64] <= (cfg_index == 2'(i)) ? cfg_wdata : sw_q[i];
				end
				idx_q <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if ((req_func == FUNC_BELOW || req_func == FUNC_ROLL)
							&& req.bound == 32'd0) begin
							state_q <= S_RESP;
						end else if (req_func == FUNC_NONE || seed_q == '0) begin
							state_q <= S_RESP;
						end else if (req_func == FUNC_BELOW || req_func == FUNC_ROLL) begin
							state_q <= S_DIVM;
						end else begin
							state_q <= S_DRAW;
							case (req_func)
								FUNC_BYTE, FUNC_BOOL: left_q <= 4'd1;
								FUNC_U16: left_q <= 4'd2;
								FUNC_U32: left_q <= 4'd4;
								default: left_q <= 4'd8;
							endcase
						end
					end
				end
				S_DRAW: begin
					if (idx_q == 6'(SeedBytes)) begin
						state_q <= S_HASH;
					end else begin
						idx_q  <= idx_q + 6'd1;
						left_q <= left_q - 4'd1;
						if (left_q == 4'd1) begin
							if (func_q == FUNC_BELOW || func_q == FUNC_ROLL) begin
								if (acc_next < m_q) begin
									state_q <= S_DIVX;
								end else begin
									left_q <= 4'd8;
								end
							end else begin
								state_q <= S_RESP;
							end
						end
					end
				end
				S_HASH: begin
					if (sha_done) begin
						seed_q  <= digest;
						idx_q   <= '0;
						state_q <= S_DRAW;
					end
				end
				S_DIVM: begin
					if (div_done) begin
						left_q  <= 4'd8;
						state_q <= S_DRAW;
					end
				end
				S_DIVX: begin
					if (div_done) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= req_func;
			bound_q <= req.bound;
			numer_q <= req.numer;
			acc_q   <= '0;
			value_q <= '0;
			if ((req_func == FUNC_BELOW || req_func == FUNC_ROLL) && req.bound == 32'd0) begin
				error_q <= ERR_ZERO_BOUND;
			end else if (req_func != FUNC_NONE && seed_q == '0) begin
				error_q <= ERR_NOT_SEEDED;
			end else begin
				error_q <= ERR_OK;
			end
		end
		if (state_q == S_DRAW && idx_q != 6'(SeedBytes)) begin
			acc_q <= (left_q == 4'd1) ? '0 : acc_next;
			if (left_q == 4'd1) begin
				value_q <= (func_q == FUNC_BOOL) ? {63'd0, acc_next[0]} : acc_next;
			end
		end
		if (state_q == S_DIVM && div_done) begin
			m_q <= 64'hffff_ffff_ffff_ffff - {32'd0, div_rem};
		end
		if (state_q == S_DIVX && div_done) begin
			value_q <= (func_q == FUNC_ROLL) ? {63'd0, (div_rem < numer_q)} : {32'd0, div_rem};
		end
	end

	`HCRS_ASSERT_NOW(a_rsp_blocks_req, rsp.valid, !req.ready)
	`HCRS_ASSERT_NOW(a_idx_range, 1'b1, idx_q <= 6'(SeedBytes))
	`HCRS_ASSERT_NOW(a_sha_done_in_hash, sha_done, state_q == S_HASH)
	`HCRS_ASSERT_NEXT(a_hash_starts, sha_start, state_q == S_HASH)

endmodule
